// ===== hdl/fldt_pkg.sv =====
// shared types, codes and constants of the frame-learned device table
package fldt_pkg;

  // widths sized for a table of up to 256 slots
  localparam int SLOT_W  = 8;
  localparam int COUNT_W = 9;

  // input action codes
  localparam logic [1:0] ACT_BYTE = 2'd0;
  localparam logic [1:0] ACT_TICK = 2'd1;
  localparam logic [1:0] ACT_READ = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_LEARN = 2'd0;
  localparam logic [1:0] KIND_TICK  = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  // learn outcomes
  localparam logic [1:0] STAT_REFRESHED = 2'd0;
  localparam logic [1:0] STAT_INSERTED  = 2'd1;
  localparam logic [1:0] STAT_FULL      = 2'd2;

  // configuration register indexes
  localparam logic REG_ENABLED   = 1'b0;
  localparam logic REG_AGE_LIMIT = 1'b1;

  localparam logic [15:0] AGE_LIMIT_RESET = 16'd50;

  // frame parser positions
  localparam logic [4:0] POS_IDLE      = 5'd0;
  localparam logic [4:0] POS_INNER     = 5'd1;
  localparam logic [4:0] POS_HDR_FIRST = 5'd2;
  localparam logic [4:0] POS_HDR_LAST  = 5'd6;
  localparam logic [4:0] POS_TYPE      = 5'd7;
  localparam logic [4:0] POS_EUI_LEN   = 5'd8;
  localparam logic [4:0] POS_EUI_FIRST = 5'd9;
  localparam logic [4:0] POS_EUI_LAST  = 5'd16;
  localparam logic [4:0] POS_MODEL_LEN = 5'd17;

  // frame constants and length budget
  localparam logic [7:0] HDR_LEN       = 8'd5;
  localparam logic [7:0] TYPE_ANNOUNCE = 8'h00;
  localparam logic [7:0] EUI_LEN_CODE  = 8'h08;
  localparam logic [7:0] TYPE_PART     = 8'd1;
  localparam logic [7:0] EUI_PART      = 8'd9;

  // command carried by a token down the cell chain
  typedef enum logic [1:0] {
    CMD_SCAN,
    CMD_INSERT,
    CMD_TICK,
    CMD_READ
  } cmd_t;

  // top-level sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  // token handed from cell to cell
  typedef struct packed {
    logic               valid;
    cmd_t               op;
    logic [63:0]        eui;
    logic [SLOT_W-1:0]  index;
    logic               hit;
    logic [SLOT_W-1:0]  hit_idx;
    logic               free_ok;
    logic [SLOT_W-1:0]  free_idx;
    logic [COUNT_W-1:0] count;
    logic               rd_valid;
    logic [63:0]        rd_eui;
    logic [15:0]        rd_age;
  } token_t;

  // fixed header byte expected at a header position
  function automatic logic [7:0] hdr_byte(input logic [4:0] pos);
    logic [7:0] b;
    logic [4:0] off;
    off = pos - POS_HDR_FIRST;
    case (off)
      5'd0:    b = 8'hEF;
      5'd1:    b = 8'hAB;
      5'd2:    b = 8'hCD;
      5'd3:    b = 8'h12;
      5'd4:    b = 8'h34;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== hdl/fldt_parser.sv =====
// byte-wise announcement frame parser with running length checks
module fldt_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        strobe,
  input  logic        first,
  input  logic [7:0]  byte_value,
  output logic        judge,
  output logic [63:0] eui
);

  logic [4:0]  pos_r, pos_nxt;
  logic [7:0]  rem_r, rem_nxt;
  logic        dead_r, dead_nxt;
  logic [63:0] eui_r, eui_nxt;
  logic [7:0]  rem_dec;
  logic [2:0]  byte_sel;

  assign rem_dec  = rem_r - 8'd1;
  assign byte_sel = 3'(pos_r - fldt_pkg::POS_EUI_FIRST);
  assign eui      = eui_r;

  // parse step for one frame byte
  always_comb begin
    pos_nxt  = pos_r;
    rem_nxt  = rem_r;
    dead_nxt = dead_r;
    eui_nxt  = eui_r;
    judge    = 1'b0;
    if (strobe) begin
      if (first) begin
        pos_nxt  = fldt_pkg::POS_INNER;
        dead_nxt = (byte_value < fldt_pkg::HDR_LEN);
        rem_nxt  = (byte_value < fldt_pkg::HDR_LEN) ? byte_value
                                                     : byte_value - fldt_pkg::HDR_LEN;
      end else if (!dead_r) begin
        case (pos_r) inside
          fldt_pkg::POS_INNER: begin
            pos_nxt = fldt_pkg::POS_HDR_FIRST;
          end
          [fldt_pkg::POS_HDR_FIRST:fldt_pkg::POS_HDR_LAST]: begin
            if (byte_value != fldt_pkg::hdr_byte(pos_r)) dead_nxt = 1'b1;
            else pos_nxt = pos_r + 5'd1;
          end
          fldt_pkg::POS_TYPE: begin
            if (rem_r < fldt_pkg::TYPE_PART || byte_value != fldt_pkg::TYPE_ANNOUNCE) begin
              dead_nxt = 1'b1;
            end else begin
              rem_nxt = rem_r - fldt_pkg::TYPE_PART;
              pos_nxt = fldt_pkg::POS_EUI_LEN;
            end
          end
          fldt_pkg::POS_EUI_LEN: begin
            if (rem_r < fldt_pkg::EUI_PART || byte_value != fldt_pkg::EUI_LEN_CODE) begin
              dead_nxt = 1'b1;
            end else begin
              rem_nxt = rem_r - fldt_pkg::EUI_PART;
              pos_nxt = fldt_pkg::POS_EUI_FIRST;
            end
          end
          [fldt_pkg::POS_EUI_FIRST:fldt_pkg::POS_EUI_LAST]: begin
            eui_nxt[{byte_sel, 3'b000} +: 8] = byte_value;
            pos_nxt = pos_r + 5'd1;
          end
          default: begin
            // model-id length byte judges the frame; anything later is dead
            dead_nxt = 1'b1;
            if (pos_r == fldt_pkg::POS_MODEL_LEN && rem_r != 8'd0) begin
              rem_nxt = rem_dec;
              judge   = (rem_dec >= byte_value);
            end
          end
        endcase
      end
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= fldt_pkg::POS_IDLE;
      rem_r  <= 8'd0;
      dead_r <= 1'b1;
    end else begin
      pos_r  <= pos_nxt;
      rem_r  <= rem_nxt;
      dead_r <= dead_nxt;
    end
  end

  // gathered eui bytes
  always_ff @(posedge clk) begin
    eui_r <= eui_nxt;
  end

endmodule

// ===== hdl/fldt_cell.sv =====
// one device slot of the table, acting on the token as it passes
module fldt_cell #(
  parameter int IDX = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [15:0]         stamp,
  input  logic [15:0]         age_limit,
  input  fldt_pkg::token_t    tok_in,
  output fldt_pkg::token_t    tok_out
);

  localparam int SW = fldt_pkg::SLOT_W;
  localparam logic [SW-1:0] MY_IDX = SW'(IDX);

  logic             valid_r, valid_nxt;
  logic [63:0]      eui_r, eui_nxt;
  logic [15:0]      seen_r, seen_nxt;
  logic [15:0]      age;
  fldt_pkg::token_t tok_r, tok_nxt;

  assign age     = stamp - seen_r;
  assign tok_out = tok_r;

  // slot update and token annotation
  always_comb begin
    valid_nxt = valid_r;
    eui_nxt   = eui_r;
    seen_nxt  = seen_r;
    tok_nxt   = tok_in;
    if (tok_in.valid) begin
      unique case (tok_in.op)
        fldt_pkg::CMD_SCAN: begin
          if (valid_r && eui_r == tok_in.eui && !tok_in.hit) begin
            tok_nxt.hit     = 1'b1;
            tok_nxt.hit_idx = MY_IDX;
            seen_nxt        = stamp;
          end
          if (!valid_r && !tok_in.free_ok) begin
            tok_nxt.free_ok  = 1'b1;
            tok_nxt.free_idx = MY_IDX;
          end
        end
        fldt_pkg::CMD_INSERT: begin
          if (tok_in.index == MY_IDX) begin
            valid_nxt = 1'b1;
            eui_nxt   = tok_in.eui;
            seen_nxt  = stamp;
          end
        end
        fldt_pkg::CMD_TICK: begin
          if (valid_r && age > age_limit) begin
            valid_nxt     = 1'b0;
            tok_nxt.count = tok_in.count + 1'b1;
          end
        end
        fldt_pkg::CMD_READ: begin
          if (tok_in.index == MY_IDX && valid_r) begin
            tok_nxt.rd_valid = 1'b1;
            tok_nxt.rd_eui   = eui_r;
            tok_nxt.rd_age   = age;
          end
        end
        default: begin
          tok_nxt = tok_in;
        end
      endcase
    end
  end

  // slot occupancy and token stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      tok_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      tok_r   <= tok_nxt;
    end
  end

  // slot contents
  always_ff @(posedge clk) begin
    eui_r  <= eui_nxt;
    seen_r <= seen_nxt;
  end

endmodule

// ===== hdl/frame_learned_device_table_core.sv =====
// top level of the frame-learned device table with tick-based aging
// Learns devices from announcement frames fed one byte per item and keeps them
// in a row of DEVICE_SLOTS cells; a token walks the row one cell per cycle.
// A frame byte that does not complete an announcement sends no token. A tick or
// a slot read walks the token once down the cell row. A completed announcement
// walks the row once when the device is refreshed or the table is full, and
// twice when it is inserted: one walk to look for the device and the lowest free
// slot, a second walk to write it. The returned token waits while the output
// register is still full with an earlier result. Ages count modulo 65536. While
// disabled, frame bytes and ticks are taken and ignored; reads still answer.
// A waiting result sits in the output register while the next item is taken.
module frame_learned_device_table_core #(
  parameter int DEVICE_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_byte_value,
  input  logic        in_first_byte,
  input  logic [3:0]  in_slot_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [1:0]  out_learn_status,
  output logic [3:0]  out_slot,
  output logic [4:0]  out_removed_count,
  output logic        out_slot_valid,
  output logic [63:0] out_slot_eui,
  output logic [15:0] out_slot_age,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int SW = fldt_pkg::SLOT_W;

  fldt_pkg::state_t state_r, state_nxt;
  fldt_pkg::token_t head_r, head_nxt;
  fldt_pkg::token_t done_r;
  fldt_pkg::token_t tail;
  fldt_pkg::token_t chain_w [0:DEVICE_SLOTS];

  logic        enabled_r;
  logic [15:0] age_limit_r;
  logic [15:0] tick_now_r, tick_now_nxt;

  logic        in_fire, out_fire, out_free;
  logic        byte_go, tick_go, read_go, learn_go, launch;
  logic        judge;
  logic [63:0] gathered_eui;
  logic        relaunch, relaunch_go, load_out;

  logic        out_valid_r;
  logic [1:0]  kind_r, status_r;
  logic [3:0]  slot_r;
  logic [4:0]  removed_r;
  logic        slot_valid_r;
  logic [63:0] slot_eui_r;
  logic [15:0] slot_age_r;

  logic [1:0]  res_kind, res_status;
  logic [3:0]  res_slot;
  logic [4:0]  res_removed;
  logic        res_valid;
  logic [63:0] res_eui;
  logic [15:0] res_age;

  // handshakes and item decode
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid_r && out_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign byte_go   = in_fire && in_action == fldt_pkg::ACT_BYTE && enabled_r;
  assign tick_go   = in_fire && in_action == fldt_pkg::ACT_TICK && enabled_r;
  assign read_go   = in_fire && in_action == fldt_pkg::ACT_READ;
  assign learn_go  = byte_go && judge;
  assign launch    = tick_go || read_go || learn_go;
  assign relaunch  = done_r.op == fldt_pkg::CMD_SCAN && !done_r.hit && done_r.free_ok;

  // frame parser
  fldt_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .strobe     (byte_go),
    .first      (in_first_byte),
    .byte_value (in_byte_value),
    .judge      (judge),
    .eui        (gathered_eui)
  );

  // row of slot cells
  assign chain_w[0] = head_r;
  assign tail       = chain_w[DEVICE_SLOTS];

  for (genvar g = 0; g < DEVICE_SLOTS; g++) begin : g_cell
    fldt_cell #(
      .IDX (g)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .stamp     (tick_now_r),
      .age_limit (age_limit_r),
      .tok_in    (chain_w[g]),
      .tok_out   (chain_w[g+1])
    );
  end

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fldt_pkg::ST_IDLE: if (launch) state_nxt = fldt_pkg::ST_RUN;
      fldt_pkg::ST_RUN:  if (tail.valid) state_nxt = fldt_pkg::ST_DONE;
      fldt_pkg::ST_DONE: begin
        if (relaunch) state_nxt = fldt_pkg::ST_RUN;
        else if (out_free) state_nxt = fldt_pkg::ST_IDLE;
      end
      default: state_nxt = fldt_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready    = 1'b0;
    relaunch_go = 1'b0;
    load_out    = 1'b0;
    unique case (state_r)
      fldt_pkg::ST_IDLE: in_ready = 1'b1;
      fldt_pkg::ST_RUN:  in_ready = 1'b0;
      fldt_pkg::ST_DONE: begin
        relaunch_go = relaunch;
        load_out    = !relaunch && out_free;
      end
      default: in_ready = 1'b0;
    endcase
  end

  // token launch into the first cell
  always_comb begin
    head_nxt = '0;
    if (relaunch_go) begin
      head_nxt.valid = 1'b1;
      head_nxt.op    = fldt_pkg::CMD_INSERT;
      head_nxt.eui   = done_r.eui;
      head_nxt.index = done_r.free_idx;
    end else if (learn_go) begin
      head_nxt.valid = 1'b1;
      head_nxt.op    = fldt_pkg::CMD_SCAN;
      head_nxt.eui   = gathered_eui;
    end else if (tick_go) begin
      head_nxt.valid = 1'b1;
      head_nxt.op    = fldt_pkg::CMD_TICK;
    end else if (read_go) begin
      head_nxt.valid = 1'b1;
      head_nxt.op    = fldt_pkg::CMD_READ;
      head_nxt.index = SW'(in_slot_index);
    end
  end

  assign tick_now_nxt = tick_go ? tick_now_r + 16'd1 : tick_now_r;

  // result fields from the returned token
  always_comb begin
    res_kind    = fldt_pkg::KIND_LEARN;
    res_status  = fldt_pkg::STAT_REFRESHED;
    res_slot    = 4'd0;
    res_removed = 5'd0;
    res_valid   = 1'b0;
    res_eui     = 64'd0;
    res_age     = 16'd0;
    unique case (done_r.op)
      fldt_pkg::CMD_SCAN: begin
        if (done_r.hit) begin
          res_status = fldt_pkg::STAT_REFRESHED;
          res_slot   = 4'(done_r.hit_idx);
        end else begin
          res_status = fldt_pkg::STAT_FULL;
        end
      end
      fldt_pkg::CMD_INSERT: begin
        res_status = fldt_pkg::STAT_INSERTED;
        res_slot   = 4'(done_r.index);
      end
      fldt_pkg::CMD_TICK: begin
        res_kind    = fldt_pkg::KIND_TICK;
        res_removed = 5'(done_r.count);
      end
      fldt_pkg::CMD_READ: begin
        res_kind  = fldt_pkg::KIND_READ;
        res_slot  = 4'(done_r.index);
        res_valid = done_r.rd_valid;
        res_eui   = done_r.rd_eui;
        res_age   = done_r.rd_age;
      end
      default: res_kind = fldt_pkg::KIND_LEARN;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fldt_pkg::ST_IDLE;
      head_r      <= '0;
      tick_now_r  <= 16'd0;
      enabled_r   <= 1'b0;
      age_limit_r <= fldt_pkg::AGE_LIMIT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      head_r     <= head_nxt;
      tick_now_r <= tick_now_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          fldt_pkg::REG_ENABLED:   enabled_r   <= cfg_data[0];
          fldt_pkg::REG_AGE_LIMIT: age_limit_r <= cfg_data;
          default:                 enabled_r   <= enabled_r;
        endcase
      end
      if (load_out) out_valid_r <= 1'b1;
      else if (out_fire) out_valid_r <= 1'b0;
    end
  end

  // returned token and output item
  always_ff @(posedge clk) begin
    if (!rst_n) done_r <= '0;
    else if (tail.valid) done_r <= tail;
    if (load_out) begin
      kind_r       <= res_kind;
      status_r     <= res_status;
      slot_r       <= res_slot;
      removed_r    <= res_removed;
      slot_valid_r <= res_valid;
      slot_eui_r   <= res_eui;
      slot_age_r   <= res_age;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = kind_r;
  assign out_learn_status  = status_r;
  assign out_slot          = slot_r;
  assign out_removed_count = removed_r;
  assign out_slot_valid    = slot_valid_r;
  assign out_slot_eui      = slot_eui_r;
  assign out_slot_age      = slot_age_r;

  // no item is taken while a token is still in the cell row
  a_ready_chain_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !tail.valid && !head_r.valid)
    else $error("item taken while a token is in flight");

  // a token returns only while the sequencer waits for it
  a_tail_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    tail.valid |-> state_r == fldt_pkg::ST_RUN)
    else $error("token returned outside the run state");

  // an enabled tick advances the clock by one
  a_tick_advance: assert property (@(posedge clk) disable iff (!rst_n)
    tick_go |=> tick_now_r == $past(tick_now_r) + 16'd1)
    else $error("tick clock did not advance");

  // a read of a free slot reports no contents
  a_free_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !slot_valid_r |-> slot_eui_r == 64'd0 && slot_age_r == 16'd0)
    else $error("free slot read carries contents");

endmodule

// ===== bench/fldt_checker.sv =====
// scoreboard for the device table core: predicts every reply and checks the result channel
module fldt_checker #(
  parameter int DEVICE_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_byte_value,
  input  logic        in_first_byte,
  input  logic [3:0]  in_slot_index,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_kind,
  input  logic [1:0]  out_learn_status,
  input  logic [3:0]  out_slot,
  input  logic [4:0]  out_removed_count,
  input  logic        out_slot_valid,
  input  logic [63:0] out_slot_eui,
  input  logic [15:0] out_slot_age,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          pending
);
  import fldt_pkg::*;

  // announcement header, first byte on the air in the top byte
  localparam logic [39:0] FRAME_HDR = 40'hEF_AB_CD_12_34;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [3:0]  slot;
    logic [4:0]  removed;
    logic        valid;
    logic [63:0] eui;
    logic [15:0] age;
  } table_reply_t;

  table_reply_t awaited_replies [$];

  // predicted table contents
  bit          dev_live [DEVICE_SLOTS];
  logic [63:0] dev_eui  [DEVICE_SLOTS];
  logic [15:0] dev_seen [DEVICE_SLOTS];
  logic [15:0] tick_now;

  // predicted parser state and registers
  logic [4:0]  parse_at;
  logic [7:0]  bytes_left;
  bit          frame_dead;
  logic [63:0] eui_gather;
  bit          table_on;
  logic [15:0] age_limit;

  // refresh a known device, else take the lowest free slot, else report full
  function automatic bit learn_device(output table_reply_t rep);
    int i;
    rep = '0;
    rep.kind = KIND_LEARN;
    for (i = 0; i < DEVICE_SLOTS; i++) begin
      if (dev_live[i] && dev_eui[i] == eui_gather) begin
        dev_seen[i] = tick_now;
        rep.status = STAT_REFRESHED;
        rep.slot = 4'(i);
        return 1'b1;
      end
    end
    for (i = 0; i < DEVICE_SLOTS; i++) begin
      if (!dev_live[i]) begin
        dev_live[i] = 1'b1;
        dev_eui[i] = eui_gather;
        dev_seen[i] = tick_now;
        rep.status = STAT_INSERTED;
        rep.slot = 4'(i);
        return 1'b1;
      end
    end
    rep.status = STAT_FULL;
    return 1'b1;
  endfunction

  // walk one frame byte through the length and content checks
  function automatic bit take_frame_byte(input logic [7:0] b, input logic first,
                                         output table_reply_t rep);
    rep = '0;
    if (first) begin
      frame_dead = (b < HDR_LEN);
      bytes_left = frame_dead ? b : b - HDR_LEN;
      parse_at = POS_INNER;
      return 1'b0;
    end
    if (frame_dead) return 1'b0;
    if (parse_at == POS_INNER) begin
      parse_at = POS_HDR_FIRST;
    end else if (parse_at >= POS_HDR_FIRST && parse_at <= POS_HDR_LAST) begin
      if (b != FRAME_HDR[8*(POS_HDR_LAST - parse_at) +: 8]) frame_dead = 1'b1;
      else parse_at = parse_at + 5'd1;
    end else if (parse_at == POS_TYPE) begin
      if (bytes_left < TYPE_PART || b != TYPE_ANNOUNCE) begin
        frame_dead = 1'b1;
      end else begin
        bytes_left = bytes_left - TYPE_PART;
        parse_at = POS_EUI_LEN;
      end
    end else if (parse_at == POS_EUI_LEN) begin
      if (bytes_left < EUI_PART || b != EUI_LEN_CODE) begin
        frame_dead = 1'b1;
      end else begin
        bytes_left = bytes_left - EUI_PART;
        parse_at = POS_EUI_FIRST;
      end
    end else if (parse_at >= POS_EUI_FIRST && parse_at <= POS_EUI_LAST) begin
      eui_gather[8*(parse_at - POS_EUI_FIRST) +: 8] = b;
      parse_at = parse_at + 5'd1;
    end else begin
      // model-id length byte judges the frame; anything later is ignored
      frame_dead = 1'b1;
      if (parse_at != POS_MODEL_LEN || bytes_left < 8'd1) return 1'b0;
      bytes_left = bytes_left - 8'd1;
      if (bytes_left < b) return 1'b0;
      return learn_device(rep);
    end
    return 1'b0;
  endfunction

  // reply expected for one accepted item, if any
  function automatic bit next_table_reply(input logic [1:0] act, input logic [7:0] b,
                                          input logic first, input logic [3:0] idx,
                                          output table_reply_t rep);
    int i;
    int freed;
    logic [15:0] age;
    rep = '0;
    if (act == ACT_BYTE) begin
      if (!table_on) return 1'b0;
      return take_frame_byte(b, first, rep);
    end
    if (act == ACT_TICK) begin
      if (!table_on) return 1'b0;
      tick_now = tick_now + 16'd1;
      freed = 0;
      for (i = 0; i < DEVICE_SLOTS; i++) begin
        age = tick_now - dev_seen[i];
        if (dev_live[i] && age > age_limit) begin
          dev_live[i] = 1'b0;
          freed++;
        end
      end
      rep.kind = KIND_TICK;
      rep.removed = 5'(freed);
      return 1'b1;
    end
    if (act == ACT_READ) begin
      rep.kind = KIND_READ;
      rep.slot = idx;
      if (int'(idx) < DEVICE_SLOTS && dev_live[idx]) begin
        rep.valid = 1'b1;
        rep.eui = dev_eui[idx];
        rep.age = tick_now - dev_seen[idx];
      end
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // field by field comparison, one report per wrong field
  function automatic int count_mismatches(input table_reply_t exp_r, input table_reply_t got);
    int n;
    n = 0;
    if (got.kind != exp_r.kind) begin
      $error("kind: expected %0d, got %0d", exp_r.kind, got.kind);
      n++;
    end
    if (got.status != exp_r.status) begin
      $error("learn_status: expected %0d, got %0d", exp_r.status, got.status);
      n++;
    end
    if (got.slot != exp_r.slot) begin
      $error("slot: expected %0d, got %0d", exp_r.slot, got.slot);
      n++;
    end
    if (got.removed != exp_r.removed) begin
      $error("removed_count: expected %0d, got %0d", exp_r.removed, got.removed);
      n++;
    end
    if (got.valid != exp_r.valid) begin
      $error("slot_valid: expected %0d, got %0d", exp_r.valid, got.valid);
      n++;
    end
    if (got.eui != exp_r.eui) begin
      $error("slot_eui: expected %h, got %h", exp_r.eui, got.eui);
      n++;
    end
    if (got.age != exp_r.age) begin
      $error("slot_age: expected %0d, got %0d", exp_r.age, got.age);
      n++;
    end
    return n;
  endfunction

  always @(posedge clk) begin : watch
    table_reply_t rep;
    table_reply_t got;
    int errs;
    int i;
    if (!rst_n) begin
      for (i = 0; i < DEVICE_SLOTS; i++) begin
        dev_live[i] = 1'b0;
        dev_eui[i] = '0;
        dev_seen[i] = '0;
      end
      tick_now = '0;
      parse_at = '0;
      bytes_left = '0;
      frame_dead = 1'b1;
      eui_gather = '0;
      table_on = 1'b0;
      age_limit = AGE_LIMIT_RESET;
      awaited_replies.delete();
      fail_count <= 0;
      pending <= 0;
    end else begin
      errs = 0;
      // register writes
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_ENABLED) table_on = cfg_data[0];
        else age_limit = cfg_data;
      end
      // each accepted item leaves at most one reply
      if (in_valid && in_ready) begin
        if (next_table_reply(in_action, in_byte_value, in_first_byte, in_slot_index, rep))
          awaited_replies.push_back(rep);
      end
      // accepted results against the oldest awaited reply
      if (out_valid && out_ready) begin
        got = {out_kind, out_learn_status, out_slot, out_removed_count,
               out_slot_valid, out_slot_eui, out_slot_age};
        if (awaited_replies.size() == 0) begin
          $error("result of kind %0d arrived with no reply awaited", out_kind);
          errs++;
        end else begin
          errs += count_mismatches(awaited_replies.pop_front(), got);
        end
      end
      fail_count <= fail_count + errs;
      pending <= awaited_replies.size();
    end
  end

endmodule

// ===== bench/tb.sv =====
// testbench top: clock, reset, frame and tick stimulus, and the verdict for the device table
module tb;
  import fldt_pkg::*;

  localparam int RUN_LIMIT = 500000;
  // longer than an insert walk down the whole row
  localparam int WIND_DOWN = 48;
  localparam int POOL_SIZE = 24;
  localparam logic [39:0] FRAME_HDR = 40'hEF_AB_CD_12_34;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam logic [63:0] EUI_MIXED = 64'h0123_4567_89AB_CDEF;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic [1:0]  in_action = ACT_BYTE;
  logic [7:0]  in_byte_value = '0;
  logic        in_first_byte = 1'b0;
  logic [3:0]  in_slot_index = '0;
  logic        out_ready = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_index = REG_ENABLED;
  logic [15:0] cfg_data = '0;

  logic        in_ready;
  logic        out_valid;
  logic [1:0]  out_kind;
  logic [1:0]  out_learn_status;
  logic [3:0]  out_slot;
  logic [4:0]  out_removed_count;
  logic        out_slot_valid;
  logic [63:0] out_slot_eui;
  logic [15:0] out_slot_age;
  logic        cfg_ready;

  int fail_count;
  int pending;
  int sent_count = 0;
  int cycle_count = 0;
  logic [63:0] eui_pool [POOL_SIZE];

  always #1 clk = ~clk;

  frame_learned_device_table_core u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_action         (in_action),
    .in_byte_value     (in_byte_value),
    .in_first_byte     (in_first_byte),
    .in_slot_index     (in_slot_index),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_learn_status  (out_learn_status),
    .out_slot          (out_slot),
    .out_removed_count (out_removed_count),
    .out_slot_valid    (out_slot_valid),
    .out_slot_eui      (out_slot_eui),
    .out_slot_age      (out_slot_age),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  fldt_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_action         (in_action),
    .in_byte_value     (in_byte_value),
    .in_first_byte     (in_first_byte),
    .in_slot_index     (in_slot_index),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_learn_status  (out_learn_status),
    .out_slot          (out_slot),
    .out_removed_count (out_removed_count),
    .out_slot_valid    (out_slot_valid),
    .out_slot_eui      (out_slot_eui),
    .out_slot_age      (out_slot_age),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .fail_count        (fail_count),
    .pending           (pending)
  );

  // run guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // stretch of the run with no idling on either side
  function automatic bit steady_run();
    return sent_count >= 900 && sent_count < 1060;
  endfunction

  // result side: random stalls plus one long hold-off that backs up the core
  initial begin : result_sink
    bit held;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && sent_count >= 500) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      if (steady_run()) out_ready <= 1'b1;
      else out_ready <= ($urandom_range(0, 99) >= 26);
    end
  end

  // offer one item, with random idling before it now and then
  task automatic send_item(input logic [1:0] act, input logic [7:0] b, input logic first,
                           input logic [3:0] idx);
    while (!steady_run() && $urandom_range(0, 99) < 26) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_byte_value <= b;
    in_first_byte <= first;
    in_slot_index <= idx;
    do @(posedge clk); while (!in_ready);
    sent_count++;
  endtask

  // tick or read with the unused fields scrambled
  task automatic send_ctrl(input logic [1:0] act, input logic [3:0] idx);
    send_item(act, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), idx);
  endtask

  // announcement frame; one byte may be overwritten and the frame cut short
  task automatic send_frame(input logic [63:0] eui, input int len, input int mlen,
                            input int bad_pos, input logic [7:0] bad_val, input int keep,
                            input int trail);
    logic [7:0] frame_bytes [$];
    int k;
    int n;
    frame_bytes.push_back(8'(len));
    frame_bytes.push_back(8'($urandom_range(0, 255)));
    for (k = 0; k < 5; k++) frame_bytes.push_back(FRAME_HDR[8*(4-k) +: 8]);
    frame_bytes.push_back(TYPE_ANNOUNCE);
    frame_bytes.push_back(EUI_LEN_CODE);
    for (k = 0; k < 8; k++) frame_bytes.push_back(eui[8*k +: 8]);
    frame_bytes.push_back(8'(mlen));
    for (k = 0; k < trail; k++) frame_bytes.push_back(8'($urandom_range(0, 255)));
    if (bad_pos >= 0) frame_bytes[bad_pos] = bad_val;
    n = (keep > 0) ? keep : frame_bytes.size();
    for (k = 0; k < n; k++)
      send_item(ACT_BYTE, frame_bytes[k], k == 0, 4'($urandom_range(0, 15)));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (WIND_DOWN) @(posedge clk);
  endtask

  task automatic set_config(input logic en, input logic [15:0] limit);
    cfg_valid <= 1'b1;
    cfg_index <= REG_ENABLED;
    cfg_data <= {15'($urandom_range(0, 32767)), en};
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_AGE_LIMIT;
    cfg_data <= limit;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // mostly good announcements from a device pool, with ticks, reads and noise
  task automatic random_item(input int tick_pct);
    int r;
    int len;
    int mlen;
    int bad;
    int keep;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(16, 255) : $urandom_range(16, 40);
      case ($urandom_range(0, 9))
        0:       mlen = len - 15;
        1:       mlen = len - 16;
        default: mlen = $urandom_range(0, len - 16);
      endcase
      bad = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 17) : -1;
      keep = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 17) : 0;
      send_frame(eui_pool[$urandom_range(0, POOL_SIZE - 1)], len, mlen, bad,
                 8'($urandom_range(0, 255)), keep, $urandom_range(0, 2));
    end else if (r < 60 + tick_pct) begin
      send_ctrl(ACT_TICK, 4'($urandom_range(0, 15)));
    end else if (r < 88) begin
      send_ctrl(ACT_READ, 4'($urandom_range(0, 15)));
    end else if (r < 96) begin
      send_item(ACT_BYTE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                4'($urandom_range(0, 15)));
    end else begin
      send_ctrl(ACT_UNUSED, 4'($urandom_range(0, 15)));
    end
  endtask

  initial begin : stimulus
    int k;
    int target;
    eui_pool[0] = '0;
    eui_pool[1] = '1;
    for (k = 2; k < POOL_SIZE; k++) eui_pool[k] = {32'($urandom), 32'($urandom)};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // disabled after reset: bytes and ticks ignored, reads still answered
    send_frame('1, 16, 0, -1, 8'h00, 0, 0);
    send_ctrl(ACT_TICK, 4'd0);
    send_item(ACT_READ, 8'hFF, 1'b1, 4'd0);
    send_item(ACT_UNUSED, 8'h00, 1'b0, 4'hF);
    drain();
    set_config(1'b1, 16'd1);

    // inserts, exact length fit with trailing bytes, refresh
    send_frame('0, 255, 0, -1, 8'h00, 0, 0);
    send_frame('1, 16, 0, -1, 8'h00, 0, 3);
    send_frame('0, 20, 4, -1, 8'h00, 0, 0);
    // broken frames: model-id too long, length underflow, no room for each part
    send_frame(EUI_MIXED, 20, 5, -1, 8'h00, 0, 0);
    send_frame(EUI_MIXED, 16, 0, 0, 8'd4, 0, 0);
    send_frame(EUI_MIXED, 16, 0, 0, 8'd5, 0, 0);
    send_frame(EUI_MIXED, 16, 0, 0, 8'd14, 0, 0);
    send_frame(EUI_MIXED, 16, 0, 0, 8'd15, 0, 0);
    // wrong header, type and eui length bytes
    send_frame(EUI_MIXED, 30, 0, 4, 8'h00, 0, 0);
    send_frame(EUI_MIXED, 30, 0, 7, 8'h01, 0, 0);
    send_frame(EUI_MIXED, 30, 0, 8, 8'h07, 0, 0);
    // frame cut short, then a restart that succeeds
    send_frame(EUI_MIXED, 30, 0, -1, 8'h00, 12, 0);
    send_frame(EUI_MIXED, 30, 3, -1, 8'h00, 0, 0);
    send_ctrl(ACT_READ, 4'd0);
    send_ctrl(ACT_READ, 4'd1);
    send_ctrl(ACT_READ, 4'd2);
    send_ctrl(ACT_READ, 4'd15);
    // with a limit of one the second tick frees everything
    send_ctrl(ACT_TICK, 4'd0);
    send_ctrl(ACT_TICK, 4'd0);
    send_ctrl(ACT_READ, 4'd2);
    drain();

    // no aging: the table fills and later devices are dropped
    set_config(1'b1, 16'hFFFF);
    target = sent_count + 550;
    while (sent_count < target) random_item(0);
    drain();

    // short limit: the whole table ages out on one tick, then churns
    set_config(1'b1, 16'd3);
    repeat (4) send_ctrl(ACT_TICK, 4'($urandom_range(0, 15)));
    target = sent_count + 200;
    while (sent_count < target) random_item(14);
    drain();

    // disabled again with a random limit
    set_config(1'b0, 16'($urandom_range(1, 65535)));
    target = sent_count + 40;
    while (sent_count < target) random_item(14);
    drain();

    set_config(1'b1, 16'd1);
    target = sent_count + 100;
    while (sent_count < target) random_item(20);
    drain();

    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
